// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IJS_ASSERT(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);
`define IJS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`else
`define IJS_ASSERT(lbl, clk, rstn, expr, msg)
`define IJS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/ijs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ijs_pkg;
    localparam int INTERVAL_BITS_DEF = 24;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int INDEX_BITS_DEF    = 21;
    localparam int VAR_BITS          = 64;
    localparam int ROOT_BITS         = 32;
    localparam int SAMPLE_COUNT_RESET = 1000;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic REG_SAMPLE_COUNT = 1'b0;
    localparam logic REG_NOMINAL      = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DQ_GO,
        S_DQ_WAIT,
        S_SQ,
        S_SCALE,
        S_DV_GO,
        S_DV_WAIT,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_OUT
    } state_t;
endpackage
`default_nettype wire

// ===== rtl/ijs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ijs_div
    import ijs_pkg::*;
#(
    parameter int DIVISOR_BITS = INDEX_BITS_DEF + 1
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [VAR_BITS-1:0]     dividend,
    input  wire logic [DIVISOR_BITS-1:0] divisor,
    output logic                         done,
    output logic [VAR_BITS-1:0]          quotient
);
    localparam int CW = $clog2(VAR_BITS + 1);

    logic [VAR_BITS-1:0]     work_reg;
    logic [DIVISOR_BITS-1:0] div_reg;
    logic [DIVISOR_BITS-1:0] rem_reg;
    logic [CW-1:0]           cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;
    logic [DIVISOR_BITS:0]   rem_sh;
    logic                    fits;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        rem_sh = {rem_reg, work_reg[VAR_BITS-1]};
        fits   = (rem_sh >= {1'b0, div_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(VAR_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift register holds dividend bits above, quotient bits below
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            div_reg  <= divisor;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[VAR_BITS-2:0], fits};
            rem_reg  <= fits ? DIVISOR_BITS'(rem_sh - {1'b0, div_reg})
                             : DIVISOR_BITS'(rem_sh);
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg;
endmodule
`default_nettype wire

// ===== rtl/ijs_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ijs_sqrt
    import ijs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [VAR_BITS-1:0]  value,
    output logic                      done,
    output logic [ROOT_BITS-1:0]      root
);
    localparam int CW = $clog2(ROOT_BITS + 1);
    localparam int RW = ROOT_BITS + 2;

    logic [VAR_BITS-1:0]  val_reg;
    logic [ROOT_BITS-1:0] root_reg;
    logic [RW-1:0]        rem_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [RW-1:0]        rem_sh;
    logic [RW-1:0]        trial;
    logic                 fits;

    // two radicand bits per cycle, one root digit
    always_comb
    begin
        rem_sh = {rem_reg[RW-3:0], val_reg[VAR_BITS-1 -: 2]};
        trial  = {root_reg, 2'b01};
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(ROOT_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= value;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            val_reg  <= {val_reg[VAR_BITS-3:0], 2'b00};
            root_reg <= {root_reg[ROOT_BITS-2:0], fits};
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

// ===== rtl/interval_jitter_statistics_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Interval jitter statistics.
// Input channel (in_valid/in_stall): operation 0 arms a run seeded with the
// nominal interval, operation 1 delivers one interval sample in ticks.
// Output channel (out_valid/out_stall): one word per finished run with mean
// and standard deviation (Q24.16), min, max and the sample index of each.
// Configuration: cfg_we/cfg_index/cfg_data, write only while idle.
// A sample runs, from acceptance to the next acceptance, through two
// passes of the bit-serial divider (one quotient bit per cycle), a bit-serial
// square of the mean step and a bit-serial scale by index+1. A mean step
// wider than 32 bits skips the square and the scale. The last sample of a
// run adds the square root, one root bit per cycle.
// Samples arriving while not armed are dropped.
// Reset clears the run state and loads sample_count = 1000, nominal = 0.
// The result sits in an output register; the block keeps accepting words
// while it waits, but stalls its input while it processes a sample, and
// also if a run finishes before the previous result is taken.
module interval_jitter_statistics_top
    import ijs_pkg::*;
#(
    parameter int INTERVAL_BITS = INTERVAL_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int INDEX_BITS    = INDEX_BITS_DEF
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic                                   cfg_index,
    input  wire logic [((INTERVAL_BITS > INDEX_BITS) ?
                        INTERVAL_BITS : INDEX_BITS)-1:0] cfg_data,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic                                   operation,
    input  wire logic [INTERVAL_BITS-1:0]               interval_ticks,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [INTERVAL_BITS+FRACTION_BITS-1:0]      mean_interval,
    output logic [INTERVAL_BITS+FRACTION_BITS-1:0]      std_interval,
    output logic [INTERVAL_BITS-1:0]                    max_interval,
    output logic [INDEX_BITS-1:0]                       max_position,
    output logic [INTERVAL_BITS-1:0]                    min_interval,
    output logic [INDEX_BITS-1:0]                       min_position
);
`include "assert_macros.svh"

    localparam int MW = INTERVAL_BITS + FRACTION_BITS;
    localparam int NW = INDEX_BITS + 1;
    localparam int MCW = $clog2(ROOT_BITS + 1);
    localparam logic [INDEX_BITS-1:0] COUNT_RST = INDEX_BITS'(SAMPLE_COUNT_RESET);

    state_t state_reg, state_next;

    logic [INDEX_BITS-1:0]    sample_count_reg;
    logic [INTERVAL_BITS-1:0] nominal_reg;
    logic                     armed_reg;
    logic [INDEX_BITS-1:0]    idx_reg;
    logic [MW-1:0]            mean_reg;
    logic [VAR_BITS-1:0]      var_reg;
    logic [INTERVAL_BITS-1:0] max_reg;
    logic [INDEX_BITS-1:0]    max_idx_reg;
    logic [INTERVAL_BITS-1:0] min_reg;
    logic [INDEX_BITS-1:0]    min_idx_reg;
    logic [MW-1:0]            diff_reg;
    logic                     neg_reg;
    logic [VAR_BITS-1:0]      term_reg;

    // serial multiplier
    logic [VAR_BITS-1:0]  acc_reg;
    logic [VAR_BITS-1:0]  mcand_reg;
    logic [ROOT_BITS-1:0] mplier_reg;
    logic [MCW-1:0]       mcnt_reg;
    logic [VAR_BITS:0]    mul_sum;
    logic [VAR_BITS-1:0]  mul_next;

    logic                 out_valid_reg;
    logic [MW-1:0]        out_mean_reg;
    logic [MW-1:0]        out_std_reg;
    logic [INTERVAL_BITS-1:0] out_max_reg;
    logic [INDEX_BITS-1:0]    out_max_idx_reg;
    logic [INTERVAL_BITS-1:0] out_min_reg;
    logic [INDEX_BITS-1:0]    out_min_idx_reg;

    logic                 in_take;
    logic                 sample_ok;
    logic [MW-1:0]        t_val;
    logic [NW-1:0]        n1;
    logic                 div_start;
    logic                 div_done;
    logic [VAR_BITS-1:0]  div_dividend;
    logic [NW-1:0]        div_divisor;
    logic [VAR_BITS-1:0]  div_q;
    logic                 sqrt_start;
    logic                 sqrt_done;
    logic [ROOT_BITS-1:0] sqrt_root;
    logic [MW-1:0]        q_val;
    logic                 q_big;
    logic [VAR_BITS-1:0]  keep;
    logic [VAR_BITS:0]    var_sum;
    logic                 out_free;

    // arithmetic units; the divider is shared by both passes
    ijs_div #(.DIVISOR_BITS(NW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    ijs_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (var_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // datapath helpers
    always_comb
    begin
        in_take   = in_valid && !in_stall;
        sample_ok = armed_reg && (idx_reg <= sample_count_reg) && (idx_reg != '0);
        t_val     = {interval_ticks, {FRACTION_BITS{1'b0}}};
        n1        = NW'({1'b0, idx_reg} + 1'b1);
        q_val     = div_q[MW-1:0];
        q_big     = ({{(VAR_BITS-MW){1'b0}}, q_val} > VAR_BITS'(64'hFFFF_FFFF));
        keep      = var_reg - div_q;
        var_sum   = {1'b0, keep} + {1'b0, term_reg};
        mul_sum   = {1'b0, acc_reg[VAR_BITS-2:0], 1'b0}
                  + (mplier_reg[ROOT_BITS-1] ? {1'b0, mcand_reg} : '0);
        mul_next  = (acc_reg[VAR_BITS-1] || mul_sum[VAR_BITS]) ? '1
                                                              : mul_sum[VAR_BITS-1:0];
        out_free  = !out_valid_reg || !out_stall;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && operation == OP_SAMPLE && sample_ok)
                    state_next = S_DQ_GO;
            end
            S_DQ_GO:     state_next = S_DQ_WAIT;
            S_DQ_WAIT:
            begin
                if (div_done)
                    state_next = q_big ? S_DV_GO : S_SQ;
            end
            S_SQ:
            begin
                if (mcnt_reg == MCW'(1))
                    state_next = S_SCALE;
            end
            S_SCALE:
            begin
                if (mcnt_reg == MCW'(1))
                    state_next = S_DV_GO;
            end
            S_DV_GO:     state_next = S_DV_WAIT;
            S_DV_WAIT:
            begin
                if (div_done)
                    state_next = (idx_reg == sample_count_reg) ? S_SQRT_GO : S_IDLE;
            end
            S_SQRT_GO:   state_next = S_SQRT_WAIT;
            S_SQRT_WAIT:
            begin
                if (sqrt_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall     = (state_reg != S_IDLE);
        div_start    = (state_reg == S_DQ_GO) || (state_reg == S_DV_GO);
        div_dividend = (state_reg == S_DQ_GO) ? {{(VAR_BITS-MW){1'b0}}, diff_reg} : var_reg;
        div_divisor  = (state_reg == S_DQ_GO) ? n1 : {1'b0, idx_reg};
        sqrt_start   = (state_reg == S_SQRT_GO);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sample_count_reg <= COUNT_RST;
            nominal_reg      <= '0;
            armed_reg        <= 1'b0;
            idx_reg          <= INDEX_BITS'(1);
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SAMPLE_COUNT: sample_count_reg <= cfg_data[INDEX_BITS-1:0];
                    REG_NOMINAL:      nominal_reg      <= cfg_data[INTERVAL_BITS-1:0];
                    default:          ;
                endcase
            end
            if (in_take && operation == OP_START)
            begin
                armed_reg <= 1'b1;
                idx_reg   <= INDEX_BITS'(1);
            end
            if (state_reg == S_DV_WAIT && div_done && idx_reg != sample_count_reg)
                idx_reg <= n1[INDEX_BITS-1:0];
            if (state_reg == S_OUT && out_free)
            begin
                idx_reg   <= n1[INDEX_BITS-1:0];
                armed_reg <= 1'b0;
            end
            // output word register
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // run statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg    <= '0;
            var_reg     <= '0;
            max_reg     <= '0;
            max_idx_reg <= '0;
            min_reg     <= '0;
            min_idx_reg <= '0;
        end
        else if (in_take && operation == OP_START)
        begin
            mean_reg    <= {nominal_reg, {FRACTION_BITS{1'b0}}};
            var_reg     <= '0;
            max_reg     <= nominal_reg;
            min_reg     <= nominal_reg;
            max_idx_reg <= '0;
            min_idx_reg <= '0;
        end
        else
        begin
            if (in_take && sample_ok)
            begin
                if (interval_ticks > max_reg)
                begin
                    max_reg     <= interval_ticks;
                    max_idx_reg <= idx_reg;
                end
                if (interval_ticks < min_reg)
                begin
                    min_reg     <= interval_ticks;
                    min_idx_reg <= idx_reg;
                end
            end
            if (state_reg == S_DQ_WAIT && div_done)
                mean_reg <= neg_reg ? (mean_reg - q_val) : (mean_reg + q_val);
            if (state_reg == S_DV_WAIT && div_done)
                var_reg <= var_sum[VAR_BITS] ? '1 : var_sum[VAR_BITS-1:0];
        end
    end

    // mean step, square and scale, and the output word
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            neg_reg  <= (t_val < mean_reg);
            diff_reg <= (t_val < mean_reg) ? (mean_reg - t_val) : (t_val - mean_reg);
        end
        if (state_reg == S_DQ_WAIT && div_done)
        begin
            term_reg   <= '1;
            acc_reg    <= '0;
            mcand_reg  <= {{(VAR_BITS-MW){1'b0}}, q_val};
            mplier_reg <= ROOT_BITS'(q_val);
            mcnt_reg   <= MCW'(ROOT_BITS);
        end
        else if (state_reg == S_SQ)
        begin
            mplier_reg <= {mplier_reg[ROOT_BITS-2:0], 1'b0};
            mcnt_reg   <= mcnt_reg - 1'b1;
            if (mcnt_reg == MCW'(1))
            begin
                acc_reg    <= '0;
                mcand_reg  <= mul_next;
                mplier_reg <= ROOT_BITS'(n1) << (ROOT_BITS - NW);
                mcnt_reg   <= MCW'(NW);
            end
            else
                acc_reg <= mul_next;
        end
        else if (state_reg == S_SCALE)
        begin
            acc_reg    <= mul_next;
            mplier_reg <= {mplier_reg[ROOT_BITS-2:0], 1'b0};
            mcnt_reg   <= mcnt_reg - 1'b1;
            if (mcnt_reg == MCW'(1))
                term_reg <= mul_next;
        end
        if (state_reg == S_OUT && out_free)
        begin
            out_mean_reg    <= mean_reg;
            out_std_reg     <= MW'(sqrt_root);
            out_max_reg     <= max_reg;
            out_max_idx_reg <= max_idx_reg;
            out_min_reg     <= min_reg;
            out_min_idx_reg <= min_idx_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mean_interval = out_mean_reg;
    assign std_interval  = out_std_reg;
    assign max_interval  = out_max_reg;
    assign max_position  = out_max_idx_reg;
    assign min_interval  = out_min_reg;
    assign min_position  = out_min_idx_reg;

    `IJS_ASSERT_IMPLY(a_div_done_state, clk, rst_n, div_done, (state_reg == S_DQ_WAIT) || (state_reg == S_DV_WAIT), "divider finished outside a wait state")
    `IJS_ASSERT_IMPLY(a_sqrt_done_state, clk, rst_n, sqrt_done, state_reg == S_SQRT_WAIT, "square root finished outside its wait state")
    `IJS_ASSERT_IMPLY(a_out_from_run, clk, rst_n, $rose(out_valid_reg), $past(state_reg == S_OUT) && !armed_reg, "result word without a finished run")
endmodule
`default_nettype wire
